// ===== rtl/rsp_pkg.sv =====
// Shared types, constants and helpers for the RESP stream parser.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps
`default_nettype none
package rsp_pkg;

  localparam int DEPTH   = 32;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int LVL_W   = $clog2(DEPTH + 1);
  localparam int CNT_W   = 32;

  // token kinds
  localparam logic [3:0] TK_SIMPLE_BYTE = 4'd0;
  localparam logic [3:0] TK_ERROR_BYTE  = 4'd1;
  localparam logic [3:0] TK_BULK_BYTE   = 4'd2;
  localparam logic [3:0] TK_SIMPLE_END  = 4'd3;
  localparam logic [3:0] TK_ERROR_END   = 4'd4;
  localparam logic [3:0] TK_INTEGER     = 4'd5;
  localparam logic [3:0] TK_BULK_START  = 4'd6;
  localparam logic [3:0] TK_BULK_END    = 4'd7;
  localparam logic [3:0] TK_NULL_BULK   = 4'd8;
  localparam logic [3:0] TK_ARRAY_START = 4'd9;
  localparam logic [3:0] TK_NULL_ARRAY  = 4'd10;
  localparam logic [3:0] TK_MALFORMED   = 4'd11;

  // malformed codes
  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_MARKER     = 4'd1;
  localparam logic [3:0] ERR_INTEGER    = 4'd2;
  localparam logic [3:0] ERR_BULK_LEN   = 4'd3;
  localparam logic [3:0] ERR_BULK_LONG  = 4'd4;
  localparam logic [3:0] ERR_BULK_CRLF  = 4'd5;
  localparam logic [3:0] ERR_ARRAY_LEN  = 4'd6;
  localparam logic [3:0] ERR_ARRAY_LONG = 4'd7;
  localparam logic [3:0] ERR_TOO_DEEP   = 4'd8;

  // configuration register indexes
  localparam logic [1:0] REG_MAX_BULK    = 2'd0;
  localparam logic [1:0] REG_MAX_ARRAY   = 2'd1;
  localparam logic [1:0] REG_MAX_NESTING = 2'd2;

  localparam logic [31:0] MAX_BULK_RST    = 32'd536870912;
  localparam logic [31:0] MAX_ARRAY_RST   = 32'd1048576;
  localparam logic [5:0]  MAX_NESTING_RST = 6'd32;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  data;
    logic [63:0] value;
    logic [5:0]  closed;
    logic        msg_end;
    logic [3:0]  err;
  } tok_t;

  typedef struct packed {
    logic             clear;
    logic             push;
    logic [CNT_W-1:0] push_val;
    logic             complete;
  } stack_req_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [LVL_W-1:0] level_after;
    logic [LVL_W-1:0] pops;
  } stack_sts_t;

  function automatic tok_t mk_tok(logic [3:0] kind, logic [7:0] data, logic [63:0] value,
                                  logic [5:0] closed, logic msg_end, logic [3:0] err);
    tok_t t;
    t.kind    = kind;
    t.data    = data;
    t.value   = value;
    t.closed  = closed;
    t.msg_end = msg_end;
    t.err     = err;
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rsp_stack.sv =====
// Stack of remaining-element counts for open arrays.
// Depends on rsp_pkg. Resolves a whole chain of array closes in a single update.
`timescale 1ns / 1ps
`default_nettype none
module rsp_stack
  import rsp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire stack_req_t req,
  output stack_sts_t      sts
);

  logic [LVL_W-1:0] level_r;
  logic [DEPTH-1:0] one_r;
  logic [CNT_W-1:0] val_r [DEPTH];

  logic             found;
  logic [IDX_W-1:0] stop;
  logic [LVL_W-1:0] level_after;
  logic [CNT_W-1:0] stop_val;

  // The element completes every frame at the top that has one left; the
  // highest frame with more than one left absorbs it.
  always_comb begin
    found = 1'b0;
    stop  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if ((LVL_W'(i) < level_r) && !one_r[i]) begin
        found = 1'b1;
        stop  = IDX_W'(i);
      end
    end
    level_after = found ? (LVL_W'(stop) + LVL_W'(1)) : '0;
    stop_val    = val_r[stop];
  end

  assign sts.level       = level_r;
  assign sts.level_after = level_after;
  assign sts.pops        = level_r - level_after;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      one_r   <= '0;
    end else if (req.clear) begin
      level_r <= '0;
    end else if (req.push) begin
      val_r[level_r[IDX_W-1:0]] <= req.push_val;
      one_r[level_r[IDX_W-1:0]] <= (req.push_val == CNT_W'(1));
      level_r                   <= level_r + LVL_W'(1);
    end else if (req.complete) begin
      level_r <= level_after;
      if (found) begin
        val_r[stop] <= stop_val - CNT_W'(1);
        one_r[stop] <= (stop_val == CNT_W'(2));
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rsp_parse.sv =====
// Per-byte parse state machine: line decoding, number accumulation, bulk tracking.
// Depends on rsp_pkg; drives the frame stack and emits up to two tokens per beat.
`timescale 1ns / 1ps
`default_nettype none
module rsp_parse
  import rsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic [7:0]  byte_in,
  input  wire logic [31:0] max_bulk,
  input  wire logic [31:0] max_array,
  input  wire logic [5:0]  max_nesting,
  input  wire stack_sts_t  stk,
  output stack_req_t       stk_req,
  output tok_t             tok0,
  output tok_t             tok1,
  output logic [1:0]       n_tok
);

  typedef enum logic [3:0] {
    M_IDLE, M_SIMPLE, M_ERROR, M_INT, M_BLEN, M_ALEN, M_BDATA, M_BCR, M_BLF
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        neg_r, neg_nxt;
  logic        dig_r, dig_nxt;
  logic        bad_r, bad_nxt;
  logic        pcr_r, pcr_nxt;
  logic [31:0] brem_r, brem_nxt;

  logic        do_cmp, do_fail, ok, bad_v;
  logic [3:0]  cmp_kind, fail_code, bk;
  logic [63:0] cmp_val, sval;
  logic        cmp_base;
  logic [67:0] prod, limit;

  always_comb begin
    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    dig_nxt   = dig_r;
    bad_nxt   = bad_r;
    pcr_nxt   = pcr_r;
    brem_nxt  = brem_r;
    tok0      = '0;
    tok1      = '0;
    n_tok     = 2'd0;
    stk_req   = '0;
    do_cmp    = 1'b0;
    do_fail   = 1'b0;
    cmp_kind  = TK_INTEGER;
    cmp_val   = '0;
    cmp_base  = 1'b0;
    fail_code = ERR_NONE;
    bk        = (mode_r == M_SIMPLE) ? TK_SIMPLE_BYTE : TK_ERROR_BYTE;
    ok        = dig_r && !bad_r;
    sval      = neg_r ? (64'd0 - acc_r) : acc_r;
    bad_v     = bad_r | pcr_r;
    prod      = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + 68'(byte_in - CH_ZERO);
    limit     = neg_r ? (68'd1 << 63) : ((68'd1 << 63) - 68'd1);

    unique case (mode_r)
      M_SIMPLE, M_ERROR: begin
        if (pcr_r) begin
          if (byte_in == CH_LF) begin
            pcr_nxt  = 1'b0;
            do_cmp   = 1'b1;
            cmp_kind = bk + 4'd3;
          end else begin
            // lone CR is data
            tok0  = mk_tok(bk, CH_CR, '0, '0, 1'b0, ERR_NONE);
            n_tok = 2'd1;
            if (byte_in != CH_CR) begin
              pcr_nxt = 1'b0;
              tok1    = mk_tok(bk, byte_in, '0, '0, 1'b0, ERR_NONE);
              n_tok   = 2'd2;
            end
          end
        end else if (byte_in == CH_CR) begin
          pcr_nxt = 1'b1;
        end else begin
          tok0  = mk_tok(bk, byte_in, '0, '0, 1'b0, ERR_NONE);
          n_tok = 2'd1;
        end
      end
      M_INT, M_BLEN, M_ALEN: begin
        if (pcr_r && byte_in == CH_LF) begin
          pcr_nxt = 1'b0;
          if (mode_r == M_INT) begin
            if (!ok) begin
              do_fail = 1'b1; fail_code = ERR_INTEGER;
            end else begin
              do_cmp = 1'b1; cmp_kind = TK_INTEGER; cmp_val = sval;
            end
          end else if (mode_r == M_BLEN) begin
            if (!ok || (neg_r && acc_r > 64'd1)) begin
              do_fail = 1'b1; fail_code = ERR_BULK_LEN;
            end else if (neg_r && acc_r == 64'd1) begin
              do_cmp = 1'b1; cmp_kind = TK_NULL_BULK;
            end else if (acc_r > {32'd0, max_bulk}) begin
              do_fail = 1'b1; fail_code = ERR_BULK_LONG;
            end else begin
              brem_nxt = acc_r[31:0];
              mode_nxt = (acc_r != 64'd0) ? M_BDATA : M_BCR;
              tok0     = mk_tok(TK_BULK_START, '0, acc_r, '0, 1'b0, ERR_NONE);
              n_tok    = 2'd1;
            end
          end else begin
            if (!ok || (neg_r && acc_r > 64'd1)) begin
              do_fail = 1'b1; fail_code = ERR_ARRAY_LEN;
            end else if (neg_r && acc_r == 64'd1) begin
              do_cmp = 1'b1; cmp_kind = TK_NULL_ARRAY;
            end else if (acc_r > {32'd0, max_array} || acc_r[63:CNT_W] != '0) begin
              do_fail = 1'b1; fail_code = ERR_ARRAY_LONG;
            end else if ((7'(stk.level) + 7'd1 > 7'(max_nesting)) ||
                         (32'(stk.level) >= 32'(DEPTH))) begin
              do_fail = 1'b1; fail_code = ERR_TOO_DEEP;
            end else if (acc_r == 64'd0) begin
              do_cmp = 1'b1; cmp_kind = TK_ARRAY_START; cmp_base = 1'b1;
            end else begin
              stk_req.push     = 1'b1;
              stk_req.push_val = acc_r[CNT_W-1:0];
              mode_nxt         = M_IDLE;
              tok0  = mk_tok(TK_ARRAY_START, '0, acc_r, '0, 1'b0, ERR_NONE);
              n_tok = 2'd1;
            end
          end
        end else begin
          pcr_nxt = 1'b0;
          bad_nxt = bad_v;
          if (byte_in == CH_CR) begin
            pcr_nxt = 1'b1;
          end else if (!bad_v) begin
            if (byte_in == CH_MINUS && !dig_r && !neg_r) begin
              neg_nxt = 1'b1;
            end else if (byte_in >= CH_ZERO && byte_in <= CH_NINE) begin
              dig_nxt = 1'b1;
              if (prod > limit) bad_nxt = 1'b1;
              else              acc_nxt = prod[63:0];
            end else begin
              bad_nxt = 1'b1;
            end
          end
        end
      end
      M_BDATA: begin
        tok0     = mk_tok(TK_BULK_BYTE, byte_in, '0, '0, 1'b0, ERR_NONE);
        n_tok    = 2'd1;
        brem_nxt = brem_r - 32'd1;
        if (brem_r == 32'd1) mode_nxt = M_BCR;
      end
      M_BCR: begin
        if (byte_in == CH_CR) mode_nxt = M_BLF;
        else begin
          do_fail = 1'b1; fail_code = ERR_BULK_CRLF;
        end
      end
      M_BLF: begin
        if (byte_in == CH_LF) begin
          do_cmp = 1'b1; cmp_kind = TK_BULK_END;
        end else begin
          do_fail = 1'b1; fail_code = ERR_BULK_CRLF;
        end
      end
      default: begin
        acc_nxt = '0;
        neg_nxt = 1'b0;
        dig_nxt = 1'b0;
        bad_nxt = 1'b0;
        pcr_nxt = 1'b0;
        case (byte_in)
          CH_PLUS:   mode_nxt = M_SIMPLE;
          CH_MINUS:  mode_nxt = M_ERROR;
          CH_COLON:  mode_nxt = M_INT;
          CH_DOLLAR: mode_nxt = M_BLEN;
          CH_STAR:   mode_nxt = M_ALEN;
          default: begin
            do_fail = 1'b1; fail_code = ERR_MARKER;
          end
        endcase
      end
    endcase

    if (do_cmp) begin
      stk_req.complete = 1'b1;
      mode_nxt = M_IDLE;
      tok0  = mk_tok(cmp_kind, '0, cmp_val, 6'(stk.pops) + 6'(cmp_base),
                     (stk.level_after == '0), ERR_NONE);
      n_tok = 2'd1;
    end
    if (do_fail) begin
      stk_req.clear = 1'b1;
      mode_nxt = M_IDLE;
      pcr_nxt  = 1'b0;
      tok0  = mk_tok(TK_MALFORMED, '0, '0, '0, 1'b0, fail_code);
      n_tok = 2'd1;
    end
    if (!en) begin
      stk_req = '0;
      n_tok   = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      acc_r  <= '0;
      neg_r  <= 1'b0;
      dig_r  <= 1'b0;
      bad_r  <= 1'b0;
      pcr_r  <= 1'b0;
      brem_r <= '0;
    end else if (en) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      neg_r  <= neg_nxt;
      dig_r  <= dig_nxt;
      bad_r  <= bad_nxt;
      pcr_r  <= pcr_nxt;
      brem_r <= brem_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rsp_fifo.sv =====
// Four-entry token queue that takes up to two tokens and gives one per beat while rd is high.
// Depends on rsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rsp_fifo
  import rsp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire tok_t       wr0,
  input  wire tok_t       wr1,
  input  wire logic [1:0] n_wr,
  input  wire logic       rd,
  output tok_t            head,
  output logic [2:0]      count
);

  tok_t       mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign head  = mem_r[rp_r];
  assign count = cnt_r;

  always_ff @(posedge clk) begin
    if (n_wr != 2'd0) mem_r[wp_r] <= wr0;
    if (n_wr == 2'd2) mem_r[wp_r + 2'd1] <= wr1;
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + n_wr;
      rp_r  <= rp_r + 2'(rd);
      cnt_r <= cnt_r + 3'(n_wr) - 3'(rd);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/resp_stream_parser_unit.sv =====
// Top level of the RESP stream parser: input register, parser, frame stack, token queue.
// Depends on rsp_pkg, rsp_stack, rsp_parse and rsp_fifo.
//
// Usage:
//   in_*  : one protocol byte per beat (in_valid / in_stall).
//   out_* : one token per beat (out_valid / out_stall); a byte may yield 0, 1 or 2
//           tokens (two only for a lone CR inside a simple or error line).
//   cfg_* : register writes (index 0 max bulk length, 1 max array length,
//           2 max nesting); cfg_ready is always high.
// Timing: a byte is held in the input register, parsed once the queue has room, and its
// tokens are written into the token queue, whose head drives out_*.
// Throughput: one byte per cycle while the receiver takes tokens; the rate is
// set by the parse step, which handles a whole byte when enabled, and by the
// four-entry token queue, which must have room for two tokens before a byte is parsed.
// Reset: parser idle, array stack empty, queue empty, registers at defaults.
// Receiver stall: tokens wait in the queue; once it holds more than two, in_stall rises and
// the held byte waits in the input register.
`timescale 1ns / 1ps
`default_nettype none
module resp_stream_parser_unit
  import rsp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_stream_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [3:0]              out_token_kind,
  output logic [7:0]              out_data_byte,
  output logic signed [63:0]      out_token_value,
  output logic [5:0]              out_arrays_closed,
  output logic                    out_message_end,
  output logic [3:0]              out_error_code,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  logic [31:0] max_bulk_r, max_array_r;
  logic [5:0]  max_nest_r;
  logic [7:0]  byte_r;
  logic        vld_r;

  stack_req_t  stk_req;
  stack_sts_t  stk_sts;
  tok_t        tok0, tok1, head;
  logic [1:0]  n_tok;
  logic [2:0]  count;
  logic        proc, rd;

  assign cfg_ready = 1'b1;
  assign proc      = vld_r && (count <= 3'd2);
  assign in_stall  = vld_r && !proc;
  assign out_valid = (count != 3'd0);
  assign rd        = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) byte_r <= in_stream_byte;
    if (!rst_n) begin
      vld_r       <= 1'b0;
      max_bulk_r  <= MAX_BULK_RST;
      max_array_r <= MAX_ARRAY_RST;
      max_nest_r  <= MAX_NESTING_RST;
    end else begin
      if (in_valid && !in_stall) vld_r <= 1'b1;
      else if (proc)             vld_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAX_BULK:    max_bulk_r  <= cfg_data;
          REG_MAX_ARRAY:   max_array_r <= cfg_data;
          REG_MAX_NESTING: max_nest_r  <= cfg_data[5:0];
          default: ;
        endcase
      end
    end
  end

  rsp_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (stk_req),
    .sts   (stk_sts)
  );

  rsp_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (proc),
    .byte_in     (byte_r),
    .max_bulk    (max_bulk_r),
    .max_array   (max_array_r),
    .max_nesting (max_nest_r),
    .stk         (stk_sts),
    .stk_req     (stk_req),
    .tok0        (tok0),
    .tok1        (tok1),
    .n_tok       (n_tok)
  );

  rsp_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr0   (tok0),
    .wr1   (tok1),
    .n_wr  (n_tok),
    .rd    (rd),
    .head  (head),
    .count (count)
  );

  assign out_token_kind    = head.kind;
  assign out_data_byte     = head.data;
  assign out_token_value   = head.value;
  assign out_arrays_closed = head.closed;
  assign out_message_end   = head.msg_end;
  assign out_error_code    = head.err;

  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n) count <= 3'd4)
    else $error("token queue overflow");
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(stk_sts.level) <= 32'(DEPTH))
    else $error("frame stack beyond depth");
  a_no_byte_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !proc) |=> (vld_r && $stable(byte_r)))
    else $error("held byte lost");
  a_malformed_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_token_kind == TK_MALFORMED) |->
      (!out_message_end && out_arrays_closed == 6'd0))
    else $error("malformed token closes arrays");

endmodule
`default_nettype wire
